>>> hw/rtl/rti_pkg.sv
`default_nettype none

package rti_pkg;

  // Coordinate format and result width.
  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int DISTW = 31;

  // Derived widths of the exact integer datapath.
  localparam int AW   = CW + 1;          // difference of two coordinates
  localparam int NW   = 2 * AW + 1;      // one cross product component
  localparam int LOW  = NW / 2;          // low slice of a cross component
  localparam int HIW  = NW - LOW;        // high slice of a cross component
  localparam int PLW  = LOW + 1 + AW;    // low partial product
  localparam int PHW  = HIW + AW;        // high partial product
  localparam int DOTW = NW + AW + 2;     // dot product of three terms
  localparam int REMW = DOTW + DISTW;    // divider remainder

  // Configuration register indexes.
  localparam int IDXW = 3;
  localparam logic [IDXW-1:0] REG_ORIGIN_X = IDXW'(0);
  localparam logic [IDXW-1:0] REG_ORIGIN_Y = IDXW'(1);
  localparam logic [IDXW-1:0] REG_ORIGIN_Z = IDXW'(2);
  localparam logic [IDXW-1:0] REG_DIR_X    = IDXW'(3);
  localparam logic [IDXW-1:0] REG_DIR_Y    = IDXW'(4);
  localparam logic [IDXW-1:0] REG_DIR_Z    = IDXW'(5);

  localparam logic [DISTW-1:0] DIST_MAX = '1;

  typedef logic [CW-1:0]   coord_t;
  typedef logic [AW-1:0]   diff_t;
  typedef logic [NW-1:0]   crs_t;
  typedef logic [DOTW-1:0] dot_t;
  typedef coord_t [2:0]    coord3_t;
  typedef diff_t  [2:0]    diff3_t;
  typedef crs_t   [2:0]    crs3_t;

  typedef struct packed {
    coord3_t o;
    coord3_t d;
  } ray_t;

  typedef struct packed {
    coord3_t v0;
    coord3_t v1;
    coord3_t v2;
  } tri_t;

  typedef struct packed {
    diff3_t a0;
    diff3_t a1;
    diff3_t a2;
    diff3_t e01;
    diff3_t e12;
  } diff_set_t;

  typedef struct packed {
    crs3_t  n;
    crs3_t  c0;
    crs3_t  c1;
    crs3_t  c2;
    diff3_t a0;
  } crs_set_t;

  typedef struct packed {
    logic             hit;
    logic [REMW-1:0]  nm;
    dot_t             dm;
  } div_in_t;

  typedef struct packed {
    logic             hit;
    logic [DISTW-1:0] q;
  } div_out_t;

  function automatic diff_t sub_ext(coord_t a, coord_t b);
    logic signed [AW-1:0] r;
    r = $signed(a) - $signed(b);
    return diff_t'(r);
  endfunction

  function automatic crs_t cross1(diff_t ai, diff_t bj, diff_t aj, diff_t bi);
    logic signed [NW-1:0] p;
    logic signed [NW-1:0] q;
    p = $signed(ai) * $signed(bj);
    q = $signed(aj) * $signed(bi);
    return crs_t'(p - q);
  endfunction

  function automatic crs3_t cross3(diff3_t a, diff3_t b);
    crs3_t r;
    r[0] = cross1(a[1], b[2], a[2], b[1]);
    r[1] = cross1(a[2], b[0], a[0], b[2]);
    r[2] = cross1(a[0], b[1], a[1], b[0]);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rti_geom.sv
`default_nettype none

module rti_geom import rti_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ray_t     ray,
  input  logic     in_valid,
  output logic     in_ready,
  input  tri_t     triangle_in,
  output logic     out_valid,
  input  logic     out_ready,
  output crs_set_t crs
);

  localparam int NST = 2;

  logic [NST-1:0] vld;
  logic [NST:0]   ld;
  diff_set_t      ds;

  assign ld[NST] = out_ready;
  for (genvar j = 0; j < NST; j++) begin : g_ld
    assign ld[j] = !vld[j] || ld[j+1];
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= in_valid;
      if (ld[1]) vld[1] <= vld[0];
    end
  end

  // Vertices relative to the ray origin, and the edges e01 and e12.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int k = 0; k < 3; k++) begin
        ds.a0[k]  <= sub_ext(triangle_in.v0[k], ray.o[k]);
        ds.a1[k]  <= sub_ext(triangle_in.v1[k], ray.o[k]);
        ds.a2[k]  <= sub_ext(triangle_in.v2[k], ray.o[k]);
        ds.e01[k] <= sub_ext(triangle_in.v1[k], triangle_in.v0[k]);
        ds.e12[k] <= sub_ext(triangle_in.v2[k], triangle_in.v1[k]);
      end
    end
  end

  // Plane normal and the edge cross products a1 x a2, a2 x a0 and a0 x a1.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      crs.n  <= cross3(ds.e01, ds.e12);
      crs.c0 <= cross3(ds.a1, ds.a2);
      crs.c1 <= cross3(ds.a2, ds.a0);
      crs.c2 <= cross3(ds.a0, ds.a1);
      crs.a0 <= ds.a0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rti_dot.sv
`default_nettype none

module rti_dot import rti_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ray_t     ray,
  input  logic     in_valid,
  output logic     in_ready,
  input  crs_set_t crs,
  output logic     out_valid,
  input  logic     out_ready,
  output div_in_t  div_in
);

  localparam int NDOT = 5;
  localparam int NST  = 4;

  logic [NST-1:0] vld;
  logic [NST:0]   ld;

  crs_t                   xs   [NDOT][3];
  diff_t                  ys   [NDOT][3];
  logic signed [PLW-1:0]  mlo  [NDOT][3];
  logic signed [PHW-1:0]  mhi  [NDOT][3];
  logic [PLW-1:0]         plo  [NDOT][3];
  logic [PHW-1:0]         phi  [NDOT][3];
  dot_t                   pcmb [NDOT][3];
  dot_t                   prod [NDOT][3];
  dot_t                   dsum [NDOT];
  logic                   nz1, nz2, nz3;
  dot_t                   den, num, absn, absd;
  logic                   hit_c;

  function automatic logic against(dot_t x, dot_t dn);
    return (x != '0) && (x[DOTW-1] != dn[DOTW-1]);
  endfunction

  assign ld[NST] = out_ready;
  for (genvar j = 0; j < NST; j++) begin : g_ld
    assign ld[j] = !vld[j] || ld[j+1];
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= in_valid;
      for (int j = 1; j < NST; j++) begin
        if (ld[j]) vld[j] <= vld[j-1];
      end
    end
  end

  // Operands: den = n.d, num = n.a0, and d.c for each edge term.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xs[0][k] = crs.n[k];  ys[0][k] = diff_t'($signed(ray.d[k]));
      xs[1][k] = crs.n[k];  ys[1][k] = crs.a0[k];
      xs[2][k] = crs.c0[k]; ys[2][k] = diff_t'($signed(ray.d[k]));
      xs[3][k] = crs.c1[k]; ys[3][k] = diff_t'($signed(ray.d[k]));
      xs[4][k] = crs.c2[k]; ys[4][k] = diff_t'($signed(ray.d[k]));
    end
  end

  // Each wide cross component is multiplied as two slices.
  always_comb begin
    for (int i = 0; i < NDOT; i++) begin
      for (int k = 0; k < 3; k++) begin
        mlo[i][k] = $signed({1'b0, xs[i][k][LOW-1:0]}) * $signed(ys[i][k]);
        mhi[i][k] = $signed(xs[i][k][NW-1:LOW]) * $signed(ys[i][k]);
        pcmb[i][k] = (DOTW'($signed(phi[i][k])) << LOW) + DOTW'($signed(plo[i][k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < NDOT; i++) begin
        for (int k = 0; k < 3; k++) begin
          plo[i][k] <= mlo[i][k];
          phi[i][k] <= mhi[i][k];
        end
      end
      nz1 <= (crs.n == '0);
    end
    if (ld[1]) begin
      for (int i = 0; i < NDOT; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod[i][k] <= pcmb[i][k];
        end
      end
      nz2 <= nz1;
    end
    if (ld[2]) begin
      for (int i = 0; i < NDOT; i++) begin
        dsum[i] <= prod[i][0] + prod[i][1] + prod[i][2];
      end
      nz3 <= nz2;
    end
  end

  // Hit decision and divider operands.
  always_comb begin
    den   = dsum[0];
    num   = dsum[1];
    absn  = num[DOTW-1] ? (~num + 1'b1) : num;
    absd  = den[DOTW-1] ? (~den + 1'b1) : den;
    hit_c = !nz3 && (den != '0) && !against(num, den) && !against(dsum[2], den)
            && !against(dsum[3], den) && !against(dsum[4], den);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      div_in.hit <= hit_c;
      div_in.nm  <= REMW'(absn) << FB;
      div_in.dm  <= absd;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rti_div.sv
`default_nettype none

module rti_div import rti_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  div_in_t  div_in,
  output logic     out_valid,
  input  logic     out_ready,
  output div_out_t div_out
);

  // One range check stage, then one quotient bit per stage.
  localparam int NST = DISTW + 1;

  logic [NST-1:0]   vld;
  logic [NST:0]     ld;
  logic [REMW-1:0]  rem  [NST];
  dot_t             dm   [NST];
  logic             hitr [NST];
  logic             sat  [NST];
  logic [DISTW-1:0] q    [NST];

  assign ld[NST] = out_ready;
  for (genvar j = 0; j < NST; j++) begin : g_ld
    assign ld[j] = !vld[j] || ld[j+1];
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= in_valid;
      for (int j = 1; j < NST; j++) begin
        if (ld[j]) vld[j] <= vld[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem[0]  <= div_in.nm;
      dm[0]   <= div_in.dm;
      hitr[0] <= div_in.hit;
      sat[0]  <= div_in.nm >= (REMW'(div_in.dm) << DISTW);
      q[0]    <= '0;
    end
  end

  for (genvar j = 1; j < NST; j++) begin : g_bit
    localparam int B = DISTW - j;
    logic [REMW-1:0]  sh;
    logic             ge;
    logic [DISTW-1:0] q_next;

    always_comb begin
      sh        = REMW'(dm[j-1]) << B;
      ge        = rem[j-1] >= sh;
      q_next    = q[j-1];
      q_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem[j]  <= ge ? (rem[j-1] - sh) : rem[j-1];
        dm[j]   <= dm[j-1];
        hitr[j] <= hitr[j-1];
        sat[j]  <= sat[j-1];
        q[j]    <= q_next;
      end
    end
  end

  always_comb begin
    div_out.hit = hitr[NST-1];
    if (!hitr[NST-1]) begin
      div_out.q = '0;
    end else if (sat[NST-1]) begin
      div_out.q = DIST_MAX;
    end else begin
      div_out.q = q[NST-1];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ray_triangle_intersect_top.sv
`default_nettype none

// Channel      Direction  Handshake             Payload
// config       in         cfg_write             cfg_index, cfg_data
// triangle     in         tri_valid/tri_stall   vertex0_x .. vertex2_z
// result       out        res_valid/res_stall   hit, distance
//
// One triangle transaction is taken every cycle while tri_stall is low; each
// gives one result transaction after two geometry stages, four dot product stages,
// 32 divider stages (one range check and one quotient bit per stage) and the
// output register. The divider chain is the longest part of the pipeline.
// Reset is synchronous and clears the valid bits and the ray registers.
// A stall on the result side lets empty stages fill before tri_stall rises.

module ray_triangle_intersect_top import rti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDXW-1:0]  cfg_index,
  input  logic [CW-1:0]    cfg_data,
  input  logic             tri_valid,
  output logic             tri_stall,
  input  logic signed [CW-1:0] vertex0_x,
  input  logic signed [CW-1:0] vertex0_y,
  input  logic signed [CW-1:0] vertex0_z,
  input  logic signed [CW-1:0] vertex1_x,
  input  logic signed [CW-1:0] vertex1_y,
  input  logic signed [CW-1:0] vertex1_z,
  input  logic signed [CW-1:0] vertex2_x,
  input  logic signed [CW-1:0] vertex2_y,
  input  logic signed [CW-1:0] vertex2_z,
  output logic             res_valid,
  input  logic             res_stall,
  output logic             hit,
  output logic [DISTW-1:0] distance
);

  ray_t     ray;
  tri_t     triangle_in;
  logic     geom_ready, geom_valid, dot_ready, dot_valid;
  logic     div_ready, div_valid;
  crs_set_t crs;
  div_in_t  div_in;
  div_out_t div_out;

  // The user must write the ray only while no transaction is in flight, so
  // every stage may read these registers directly; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      ray <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_X: ray.o[0] <= cfg_data;
        REG_ORIGIN_Y: ray.o[1] <= cfg_data;
        REG_ORIGIN_Z: ray.o[2] <= cfg_data;
        REG_DIR_X:    ray.d[0] <= cfg_data;
        REG_DIR_Y:    ray.d[1] <= cfg_data;
        REG_DIR_Z:    ray.d[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    triangle_in.v0 = {vertex0_z, vertex0_y, vertex0_x};
    triangle_in.v1 = {vertex1_z, vertex1_y, vertex1_x};
    triangle_in.v2 = {vertex2_z, vertex2_y, vertex2_x};
  end

  assign tri_stall = !geom_ready;

  rti_geom u_geom (
    .clk         (clk),
    .rst         (rst),
    .ray         (ray),
    .in_valid    (tri_valid),
    .in_ready    (geom_ready),
    .triangle_in (triangle_in),
    .out_valid   (geom_valid),
    .out_ready   (dot_ready),
    .crs         (crs)
  );

  rti_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .ray       (ray),
    .in_valid  (geom_valid),
    .in_ready  (dot_ready),
    .crs       (crs),
    .out_valid (dot_valid),
    .out_ready (div_ready),
    .div_in    (div_in)
  );

  rti_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dot_valid),
    .in_ready  (div_ready),
    .div_in    (div_in),
    .out_valid (div_valid),
    .out_ready (!res_valid || !res_stall),
    .div_out   (div_out)
  );

  // Output register: it takes the next result whenever it is empty or its
  // current transaction is being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      hit      <= div_out.hit;
      distance <= div_out.q;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rti_checker.sv
`default_nettype none

module rti_checker import rti_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             tri_stall,
  input logic             res_valid,
  input logic             res_stall,
  input logic             hit,
  input logic [DISTW-1:0] distance
);

  // A miss always reports zero distance.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !hit |-> distance == '0)
    else $error("miss with nonzero distance");

  // With the output empty every stage can advance, so no triangle is held off.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !tri_stall)
    else $error("triangle stalled with empty output");

  // No result appears straight after reset.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid after reset");

  // A held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(hit) && $stable(distance))
    else $error("stalled result changed");

endmodule

bind ray_triangle_intersect_top rti_checker u_rti_checker (.*);

`default_nettype wire
